/* hdl/adcv_pkg.sv */
// ----------------------------------------------------------------------------
// adcv_pkg: shared types and constants for the converter-to-ASCII unit
// Digit bundle type, line byte codes, scaling constants and the digit helper.
// ----------------------------------------------------------------------------
package adcv_pkg;

	localparam int CODE_W = 12;
	localparam int REF_W = 14;
	localparam int PROD_W = CODE_W + REF_W;
	localparam int MV_W = 14;
	localparam int DIGIT_W = 4;
	localparam int BYTE_W = 8;
	localparam int IDX_W = 4;
	localparam int QUEUE_DEPTH = 4;

	localparam logic [REF_W-1:0] REF_RESET = 14'd3300;
	localparam logic [CODE_W-1:0] FULL_SCALE = 12'd4095;
	localparam logic [MV_W-1:0] MV_MAX = 14'd9999;

	localparam logic [IDX_W-1:0] IDX_VOLTS = 4'd0;
	localparam logic [IDX_W-1:0] IDX_POINT = 4'd1;
	localparam logic [IDX_W-1:0] IDX_HUND = 4'd2;
	localparam logic [IDX_W-1:0] IDX_TENS = 4'd3;
	localparam logic [IDX_W-1:0] IDX_UNITS = 4'd4;
	localparam logic [IDX_W-1:0] IDX_SPACE = 4'd5;
	localparam logic [IDX_W-1:0] IDX_UNIT_V = 4'd6;
	localparam logic [IDX_W-1:0] IDX_CR = 4'd7;
	localparam logic [IDX_W-1:0] IDX_LF = 4'd8;

	localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
	localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [BYTE_W-1:0] CHAR_V = 8'h56;
	localparam logic [BYTE_W-1:0] CHAR_CR = 8'h0D;
	localparam logic [BYTE_W-1:0] CHAR_LF = 8'h0A;

	typedef struct packed {
		logic [DIGIT_W-1:0] volts;
		logic [DIGIT_W-1:0] hund;
		logic [DIGIT_W-1:0] tens;
		logic [DIGIT_W-1:0] units;
	} digits_t;

	function automatic logic [DIGIT_W-1:0] digit_of(input logic [MV_W-1:0] value,
			input logic [MV_W-1:0] unit);
		logic [DIGIT_W-1:0] d;
		d = '0;
		for (int k = 1; k <= 9; k++) begin
			if (value >= MV_W'(k) * unit) begin
				d = DIGIT_W'(k);
			end
		end
		return d;
	endfunction

endpackage

/* hdl/adcv_front.sv */
// ----------------------------------------------------------------------------
// adcv_front: sample scaling and digit split
// Multiply by the reference, divide by full scale, saturate, split into digits.
// ----------------------------------------------------------------------------
module adcv_front
	import adcv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [CODE_W-1:0] in_code,
	input  logic [REF_W-1:0]  ref_mv,
	output logic              push,
	input  logic              push_ready,
	output digits_t           push_data
);

	logic              v_s1, v_s2, v_s3, v_s4;
	logic              rdy1, rdy2, rdy3, rdy4;
	logic [PROD_W-1:0] prod_s1;
	logic [MV_W-1:0]   mv_s2;
	logic [DIGIT_W-1:0] d3_s3;
	logic [9:0]        rem_s3;
	logic [DIGIT_W-1:0] d3_s4, d2_s4;
	logic [6:0]        rem_s4;

	logic [MV_W-1:0]   q0;
	logic [14:0]       r0;
	logic [2:0]        q1;
	logic [12:0]       r1;
	logic [MV_W:0]     quot;
	logic [MV_W-1:0]   mv_next;
	logic [DIGIT_W-1:0] d3_next, d2_next, d1_next;
	logic [MV_W-1:0]   rem3_full, rem4_full, rem5_full;

	assign rdy4 = !v_s4 || push_ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	// divide by 4095: fold the high part back in twice, then one correction
	always_comb begin
		q0 = prod_s1[PROD_W-1:CODE_W];
		r0 = 15'(prod_s1[CODE_W-1:0]) + 15'(q0);
		q1 = r0[14:12];
		r1 = 13'(r0[11:0]) + 13'(q1);
		quot = 15'(q0) + 15'(q1) + 15'(r1 >= 13'(FULL_SCALE));
		mv_next = (quot > 15'(MV_MAX)) ? MV_MAX : quot[MV_W-1:0];
	end

	always_comb begin
		d3_next = digit_of(mv_s2, 14'd1000);
		rem3_full = mv_s2 - MV_W'(d3_next) * 14'd1000;
		d2_next = digit_of(MV_W'(rem_s3), 14'd100);
		rem4_full = MV_W'(rem_s3) - MV_W'(d2_next) * 14'd100;
		d1_next = digit_of(MV_W'(rem_s4), 14'd10);
		rem5_full = MV_W'(rem_s4) - MV_W'(d1_next) * 14'd10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			prod_s1 <= PROD_W'(in_code) * PROD_W'(ref_mv);
		end
		if (rdy2 && v_s1) begin
			mv_s2 <= mv_next;
		end
		if (rdy3 && v_s2) begin
			d3_s3 <= d3_next;
			rem_s3 <= rem3_full[9:0];
		end
		if (rdy4 && v_s3) begin
			d3_s4 <= d3_s3;
			d2_s4 <= d2_next;
			rem_s4 <= rem4_full[6:0];
		end
	end

	assign push = v_s4 && push_ready;
	assign push_data = '{volts: d3_s4, hund: d2_s4, tens: d1_next,
		units: rem5_full[DIGIT_W-1:0]};

endmodule

/* hdl/adcv_queue.sv */
// ----------------------------------------------------------------------------
// adcv_queue: short digit queue
// Holds converted digit sets between the scaling pipeline and the serializer.
// ----------------------------------------------------------------------------
module adcv_queue
	import adcv_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	output logic    push_ready,
	input  digits_t push_data,
	input  logic    pop,
	output logic    head_valid,
	output digits_t head_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	digits_t            mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign push_ready = (count_q != CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_data = mem_q[rd_ptr_q];
	assign do_pop = pop && head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

/* hdl/adcv_back.sv */
// ----------------------------------------------------------------------------
// adcv_back: line serializer
// Emits the nine ASCII bytes of one voltage line through an output register.
// ----------------------------------------------------------------------------
module adcv_back
	import adcv_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              head_valid,
	input  digits_t           head_data,
	output logic              pop,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [BYTE_W-1:0] out_byte,
	output logic              out_last
);

	logic [IDX_W-1:0]  idx_q;
	logic              valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              last_q;
	logic              load;
	logic [BYTE_W-1:0] char_next;

	assign load = head_valid && (!valid_q || out_ready);
	assign pop = load && (idx_q == IDX_LF);

	always_comb begin
		unique case (idx_q)
			IDX_VOLTS:  char_next = CHAR_ZERO + BYTE_W'(head_data.volts);
			IDX_POINT:  char_next = CHAR_POINT;
			IDX_HUND:   char_next = CHAR_ZERO + BYTE_W'(head_data.hund);
			IDX_TENS:   char_next = CHAR_ZERO + BYTE_W'(head_data.tens);
			IDX_UNITS:  char_next = CHAR_ZERO + BYTE_W'(head_data.units);
			IDX_SPACE:  char_next = CHAR_SPACE;
			IDX_UNIT_V: char_next = CHAR_V;
			IDX_CR:     char_next = CHAR_CR;
			IDX_LF:     char_next = CHAR_LF;
			default:    char_next = CHAR_LF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= IDX_VOLTS;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q <= (idx_q == IDX_LF) ? IDX_VOLTS : idx_q + 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= char_next;
			last_q <= (idx_q == IDX_LF);
		end
	end

	assign out_valid = valid_q;
	assign out_byte = byte_q;
	assign out_last = last_q;

`ifndef SYNTH
	a_last_is_lf: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && last_q |-> byte_q == CHAR_LF)
		else $error("line end byte is not LF");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= IDX_LF)
		else $error("byte index out of range");
	a_pop_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == IDX_VOLTS && valid_q && last_q)
		else $error("pop without line end");
`endif

endmodule

/* hdl/adc_code_to_voltage_ascii_unit.sv */
// ----------------------------------------------------------------------------
// adc_code_to_voltage_ascii_unit: converter sample to ASCII voltage line
// Scales a 12-bit sample to millivolts and streams "d.ddd V\r\n" per sample.
// ----------------------------------------------------------------------------
// Each accepted sample yields nine bytes, one per cycle while m_tready is held
// high, with tlast on the line feed. Scaling runs in a four-stage pipeline
// ahead of a small digit queue, and new samples are taken while an earlier
// line is still being sent. Values above 9999 mV read as 9.999 V. The
// reference register resets to 3300; the user must write it only while the
// unit is idle, as the unit itself does not enforce this.
module adc_code_to_voltage_ascii_unit
	import adcv_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [11:0] adc_code
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // [7:0] text_byte
	output logic        m_tlast,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data   // [13:0] reference_millivolts
);

	logic [REF_W-1:0] ref_q;
	logic             push, push_ready, head_valid, pop;
	digits_t          push_data, head_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_q <= REF_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ref_q <= cfg_data[REF_W-1:0];
		end
	end

	adcv_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_code    (s_tdata[CODE_W-1:0]),
		.ref_mv     (ref_q),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data)
	);

	adcv_queue #(.DEPTH(DEPTH)) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.push_data  (push_data),
		.pop        (pop),
		.head_valid (head_valid),
		.head_data  (head_data)
	);

	adcv_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_data  (head_data),
		.pop        (pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_byte   (m_tdata),
		.out_last   (m_tlast)
	);

endmodule

/* test/tb.sv */
// ----------------------------------------------------------------------------
// tb: testbench for adc_code_to_voltage_ascii_unit
// Streams converter samples under several reference settings. The bench
// predicts each nine-byte voltage line and checks every output word in order,
// with random gaps on both stream sides.
// ----------------------------------------------------------------------------
module tb;
	import adcv_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] text_byte;
		logic last_byte;
	} line_byte_t;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;     // [11:0] adc_code
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [7:0] m_tdata;           // [7:0] text_byte
	logic m_tlast;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [15:0] cfg_data = '0;    // [13:0] reference_millivolts

	logic [CODE_W-1:0] sample_q[$];
	line_byte_t line_q[$];
	logic [REF_W-1:0] ref_mv = REF_RESET;
	bit no_idle = 1'b0;
	int send_gap = 0;
	int recv_gap = 0;
	int idle_cycles = 0;
	int fail_cnt = 0;
	int n_samples = 0;
	int n_bytes = 0;
	int n_settings = 0;

	adc_code_to_voltage_ascii_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic int draw_gap();
		int r;
		if (no_idle) begin
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [BYTE_W-1:0] ascii_digit(input logic [MV_W-1:0] d);
		return CHAR_ZERO + BYTE_W'(d);
	endfunction

	function automatic void predict_line(input logic [CODE_W-1:0] code);
		logic [PROD_W-1:0] prod;
		logic [PROD_W-1:0] quot;
		logic [MV_W-1:0] mv;
		logic [MV_W-1:0] frac;
		prod = PROD_W'(code) * PROD_W'(ref_mv);
		quot = prod / PROD_W'(FULL_SCALE);
		mv = (quot > PROD_W'(MV_MAX)) ? MV_MAX : quot[MV_W-1:0];
		frac = MV_W'(mv % 1000);
		line_q.push_back('{ascii_digit(MV_W'(mv / 1000)), 1'b0});
		line_q.push_back('{CHAR_POINT, 1'b0});
		line_q.push_back('{ascii_digit(MV_W'(frac / 100)), 1'b0});
		line_q.push_back('{ascii_digit(MV_W'((frac / 10) % 10)), 1'b0});
		line_q.push_back('{ascii_digit(MV_W'(frac % 10)), 1'b0});
		line_q.push_back('{CHAR_SPACE, 1'b0});
		line_q.push_back('{CHAR_V, 1'b0});
		line_q.push_back('{CHAR_CR, 1'b0});
		line_q.push_back('{CHAR_LF, 1'b1});
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_line(s_tdata[CODE_W-1:0]);
				n_samples++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					s_tvalid <= 1'b0;
				end else if (sample_q.size() != 0) begin
					s_tvalid <= 1'b1;
					s_tdata <= {4'b0000, sample_q.pop_front()};
					send_gap <= draw_gap();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		line_byte_t exp_b;
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				n_bytes++;
				if (line_q.size() == 0) begin
					$error("unexpected word: text_byte 0x%02h last_byte %0b", m_tdata, m_tlast);
					fail_cnt++;
				end else begin
					exp_b = line_q.pop_front();
					if (m_tdata !== exp_b.text_byte) begin
						$error("text_byte: expected 0x%02h, actual 0x%02h",
							exp_b.text_byte, m_tdata);
						fail_cnt++;
					end
					if (m_tlast !== exp_b.last_byte) begin
						$error("last_byte: expected %0b, actual %0b", exp_b.last_byte, m_tlast);
						fail_cnt++;
					end
				end
			end
			if (recv_gap != 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap <= draw_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic wait_idle();
		@(negedge clk);
		while (sample_q.size() != 0 || s_tvalid || line_q.size() != 0) begin
			@(negedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reference(input logic [REF_W-1:0] value);
		wait_idle();
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= {2'b00, value};
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		ref_mv = value;
		n_settings++;
	endtask

	initial begin
		int r;
		logic [CODE_W-1:0] code;
		logic [REF_W-1:0] rand_refs[5];
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		sample_q = '{12'd0, 12'd4095, 12'd1, 12'd2048, 12'hAAA, 12'h555, 12'd4094};
		write_reference(14'd0);
		sample_q = '{12'd4095, 12'd1234};
		write_reference(14'd9999);
		sample_q = '{12'd4095, 12'd0, 12'd4094};
		write_reference(14'd16383);
		sample_q = '{12'd4095, 12'd2048, 12'd0, 12'd1};
		write_reference(14'd10000);
		sample_q = '{12'd4095, 12'd4094};

		rand_refs[0] = REF_W'($urandom_range(0, 9999));
		rand_refs[1] = REF_W'($urandom_range(10000, 16383));
		rand_refs[2] = REF_RESET;
		rand_refs[3] = REF_W'($urandom_range(0, 16383));
		rand_refs[4] = 14'd1;
		for (int p = 0; p < 5; p++) begin
			write_reference(rand_refs[p]);
			no_idle = (p == 2);
			for (int k = 0; k < 32; k++) begin
				r = $urandom_range(0, 9);
				if (r == 0) begin
					code = '0;
				end else if (r == 1) begin
					code = '1;
				end else begin
					code = CODE_W'($urandom_range(0, 4095));
				end
				sample_q.push_back(code);
			end
		end
		wait_idle();
		no_idle = 1'b0;

		$display("run covered %0d samples and %0d output bytes", n_samples, n_bytes);
		$display("reference writes: %0d, including zero, full range and above range",
			n_settings);
		if (fail_cnt == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
